[rtl/itoar_pkg.sv]
// Shared types, constants and the microcode encoding for the integer-to-ASCII converter.
`timescale 1ns / 1ps

package itoar_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W = $clog2(VALUE_WIDTH);
	localparam int SP_W = ADDR_W + 1;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int PC_W = 4;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] DEFAULT_BASE = 8'd10;

	// Jump conditions.
	localparam logic [2:0] COND_NONE = 3'd0;
	localparam logic [2:0] COND_ALWAYS = 3'd1;
	localparam logic [2:0] COND_IN_IDLE = 3'd2;
	localparam logic [2:0] COND_NOT_NEG = 3'd3;
	localparam logic [2:0] COND_NOT_ZERO = 3'd4;
	localparam logic [2:0] COND_DIV_BUSY = 3'd5;
	localparam logic [2:0] COND_STACK_LEFT = 3'd6;
	localparam logic [2:0] COND_NO_LINE_END = 3'd7;

	// Character selection for an emitting step.
	localparam logic [2:0] CSEL_MINUS = 3'd0;
	localparam logic [2:0] CSEL_ZERO = 3'd1;
	localparam logic [2:0] CSEL_DIGIT = 3'd2;
	localparam logic [2:0] CSEL_CR = 3'd3;
	localparam logic [2:0] CSEL_LF = 3'd4;

	// Last-mark selection.
	localparam logic [1:0] LSEL_NONE = 2'd0;
	localparam logic [1:0] LSEL_DIGIT = 2'd1;
	localparam logic [1:0] LSEL_ALWAYS = 2'd2;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value_bits;
		logic                   is_signed;
		logic [7:0]             radix;
		logic                   add_line_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic            accept;
		logic            emit;
		logic [2:0]      char_sel;
		logic [1:0]      last_sel;
		logic            negate;
		logic            div_clr;
		logic            div_step;
		logic            push;
		logic            pop;
		logic [2:0]      cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic neg;
		logic zero;
		logic div_busy;
		logic stack_left;
		logic line_end;
	} status_t;

	function automatic logic [7:0] digit_char(input logic [7:0] d);
		logic [7:0] ch;
		if (d < 8'd10) begin
			ch = CH_ZERO + d;
		end else begin
			ch = CH_UPPER_A + d - 8'd10;
		end
		return ch;
	endfunction

endpackage

[rtl/itoar_seq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module itoar_seq
	import itoar_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_free,
	input  status_t status,
	output ctrl_t   ctrl,
	output logic    go
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	// Control store.
	always_comb begin
		ctrl = '0;
		unique case (pc_q)
			4'd0: begin
				ctrl.accept = 1'b1;
				ctrl.cond   = COND_IN_IDLE;
				ctrl.target = 4'd0;
			end
			4'd1: begin
				ctrl.cond   = COND_NOT_NEG;
				ctrl.target = 4'd3;
			end
			4'd2: begin
				ctrl.emit     = 1'b1;
				ctrl.char_sel = CSEL_MINUS;
				ctrl.last_sel = LSEL_NONE;
				ctrl.negate   = 1'b1;
			end
			4'd3: begin
				ctrl.cond   = COND_NOT_ZERO;
				ctrl.target = 4'd5;
			end
			4'd4: begin
				ctrl.emit     = 1'b1;
				ctrl.char_sel = CSEL_ZERO;
				ctrl.last_sel = LSEL_DIGIT;
				ctrl.cond     = COND_ALWAYS;
				ctrl.target   = 4'd10;
			end
			4'd5: begin
				ctrl.div_clr = 1'b1;
			end
			4'd6: begin
				ctrl.div_step = 1'b1;
				ctrl.cond     = COND_DIV_BUSY;
				ctrl.target   = 4'd6;
			end
			4'd7: begin
				ctrl.push   = 1'b1;
				ctrl.cond   = COND_NOT_ZERO;
				ctrl.target = 4'd5;
			end
			4'd8: begin
				ctrl.pop = 1'b1;
			end
			4'd9: begin
				ctrl.emit     = 1'b1;
				ctrl.char_sel = CSEL_DIGIT;
				ctrl.last_sel = LSEL_DIGIT;
				ctrl.cond     = COND_STACK_LEFT;
				ctrl.target   = 4'd8;
			end
			4'd10: begin
				ctrl.cond   = COND_NO_LINE_END;
				ctrl.target = 4'd0;
			end
			4'd11: begin
				ctrl.emit     = 1'b1;
				ctrl.char_sel = CSEL_CR;
				ctrl.last_sel = LSEL_NONE;
			end
			4'd12: begin
				ctrl.emit     = 1'b1;
				ctrl.char_sel = CSEL_LF;
				ctrl.last_sel = LSEL_ALWAYS;
				ctrl.cond     = COND_ALWAYS;
				ctrl.target   = 4'd0;
			end
			default: begin
				ctrl.cond   = COND_ALWAYS;
				ctrl.target = 4'd0;
			end
		endcase
	end

	// An emitting step holds until the output register can take the character.
	assign go = !(ctrl.emit && !out_free);

	always_comb begin
		unique case (ctrl.cond)
			COND_NONE:        take = 1'b0;
			COND_ALWAYS:      take = 1'b1;
			COND_IN_IDLE:     take = !in_valid;
			COND_NOT_NEG:     take = !status.neg;
			COND_NOT_ZERO:    take = !status.zero;
			COND_DIV_BUSY:    take = status.div_busy;
			COND_STACK_LEFT:  take = status.stack_left;
			COND_NO_LINE_END: take = !status.line_end;
			default:          take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (go) begin
			pc_q <= take ? ctrl.target : pc_q + 1'b1;
		end
	end

endmodule

[rtl/itoar_datapath.sv]
// Datapath: operand registers, bit-serial divider and the digit stack.
`timescale 1ns / 1ps

module itoar_datapath
	import itoar_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_t      ctrl,
	input  logic       go,
	input  logic       in_fire,
	input  in_item_t   in_item,
	output status_t    status,
	output logic [7:0] digit_q
);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [7:0]             base_q;
	logic [7:0]             rem_q;
	logic                   neg_q;
	logic                   line_end_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SP_W-1:0]        sp_q;
	logic [7:0]             stack_q [VALUE_WIDTH];
	logic [7:0]             base_in;
	logic [8:0]             trial;
	logic                   qbit;
	logic [SP_W-1:0]        sp_dec;

	assign base_in = (in_item.radix < 8'd2) ? DEFAULT_BASE : in_item.radix;

	// One restoring-division step: shift in the next dividend bit and
	// subtract the base when it fits; the quotient bit shifts into mag_q.
	assign trial = {rem_q, mag_q[VALUE_WIDTH-1]};
	assign qbit = (trial >= {1'b0, base_q});
	assign sp_dec = sp_q - 1'b1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_q      <= in_item.value_bits;
			base_q     <= base_in;
			neg_q      <= in_item.is_signed && (base_in == DEFAULT_BASE)
				&& in_item.value_bits[VALUE_WIDTH-1];
			line_end_q <= in_item.add_line_end;
		end else if (go && ctrl.negate) begin
			mag_q <= '0 - mag_q;
		end else if (go && ctrl.div_clr) begin
			rem_q <= '0;
		end else if (go && ctrl.div_step) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], qbit};
			rem_q <= qbit ? 8'(trial - {1'b0, base_q}) : trial[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sp_q  <= '0;
		end else begin
			if (go && ctrl.div_clr) begin
				cnt_q <= '0;
			end else if (go && ctrl.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (go && ctrl.push) begin
				sp_q <= sp_q + 1'b1;
			end else if (go && ctrl.pop) begin
				sp_q <= sp_dec;
			end
		end
	end

	// Digits are produced least significant first and popped in reverse.
	always_ff @(posedge clk) begin
		if (go && ctrl.push) begin
			stack_q[sp_q[ADDR_W-1:0]] <= digit_char(rem_q);
		end
		if (go && ctrl.pop) begin
			digit_q <= stack_q[sp_dec[ADDR_W-1:0]];
		end
	end

	assign status.neg        = neg_q;
	assign status.zero       = (mag_q == '0);
	assign status.div_busy   = (cnt_q != CNT_W'(VALUE_WIDTH - 1));
	assign status.stack_left = (sp_q != '0);
	assign status.line_end   = line_end_q;

endmodule

[rtl/integer_to_ascii_radix_unit.sv]
// Top level of the integer-to-ASCII converter: handshakes, output register and checks.
`timescale 1ns / 1ps

// Converts one 32-bit value per input transfer into its ASCII characters in the
// requested base (0 and 1 select ten), most significant digit first, one output
// transfer per character with the last one marked; base ten with a signed
// negative value gives a leading minus, and the line-end flag appends CR and LF.
// The time a value takes grows with its number of digits, plus any time the output is
// held off by out_ready. It is set by the bit-serial divider, which produces one
// quotient bit per cycle for every digit. A new value is accepted only once the
// previous one has been fully handed on to the output register.
module integer_to_ascii_radix_unit
	import itoar_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	ctrl_t      ctrl;
	status_t    status;
	logic       go;
	logic       out_free;
	logic       in_fire;
	logic [7:0] digit_q;
	logic       out_valid_q;
	out_item_t  out_q;
	out_item_t  next_out;

	assign in_ready = ctrl.accept;
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	itoar_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.status   (status),
		.ctrl     (ctrl),
		.go       (go)
	);

	itoar_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.go      (go),
		.in_fire (in_fire),
		.in_item (in_data),
		.status  (status),
		.digit_q (digit_q)
	);

	always_comb begin
		unique case (ctrl.char_sel)
			CSEL_MINUS: next_out.character = CH_MINUS;
			CSEL_ZERO:  next_out.character = CH_ZERO;
			CSEL_DIGIT: next_out.character = digit_q;
			CSEL_CR:    next_out.character = CH_CR;
			CSEL_LF:    next_out.character = CH_LF;
			default:    next_out.character = CH_ZERO;
		endcase
		unique case (ctrl.last_sel)
			LSEL_NONE:   next_out.last = 1'b0;
			LSEL_DIGIT:  next_out.last = !status.stack_left && !status.line_end;
			LSEL_ALWAYS: next_out.last = 1'b1;
			default:     next_out.last = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && go) begin
			out_q <= next_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A character is only loaded when the output register is empty or draining.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit && go |-> !out_valid_q || out_ready)
		else $error("output register overwritten before transfer");

	// Every value leaves the digit stack empty before the next is taken.
	a_stack_empty_at_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !status.stack_left)
		else $error("digit stack not empty when accepting a value");

	// A pop never happens on an empty stack.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop && go |-> status.stack_left)
		else $error("digit stack underflow");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the integer-to-ASCII converter with a selectable base.
`timescale 1ns / 1ps

module tb_top;
	import itoar_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int RANDOM_VALUES = 480;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 60;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	in_item_t  pending_values[$];
	out_item_t expected_chars[$];

	int cycle_count = 0;
	int mismatch_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_timer = 0;
	int stall_mode = 0;

	integer_to_ascii_radix_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Works out the characters that one accepted value must produce.
	function automatic void predict_characters(input in_item_t item);
		logic [VALUE_WIDTH-1:0] mag;
		logic [VALUE_WIDTH-1:0] rem;
		logic [7:0]             base;
		logic [7:0]             digit_stack[VALUE_WIDTH];
		logic [7:0]             chars[$];
		int                     ndig;
		out_item_t              exp_item;
		mag = item.value_bits;
		base = item.radix;
		ndig = 0;
		if (base < 8'd2) begin
			base = DEFAULT_BASE;
		end
		// Only decimal output carries a sign; the most negative value negates to itself.
		if (item.is_signed && base == DEFAULT_BASE && mag[VALUE_WIDTH-1]) begin
			chars.push_back(CH_MINUS);
			mag = -mag;
		end
		if (mag == '0) begin
			chars.push_back(CH_ZERO);
		end else begin
			while (mag != '0) begin
				rem = mag % base;
				// Digits of ten and above run on from 'A' and wrap within the byte.
				if (rem < 10) begin
					digit_stack[ndig] = CH_ZERO + rem[7:0];
				end else begin
					digit_stack[ndig] = CH_UPPER_A + rem[7:0] - 8'd10;
				end
				ndig++;
				mag = mag / base;
			end
			for (int i = ndig - 1; i >= 0; i--) begin
				chars.push_back(digit_stack[i]);
			end
		end
		if (item.add_line_end) begin
			chars.push_back(CH_CR);
			chars.push_back(CH_LF);
		end
		for (int i = 0; i < chars.size(); i++) begin
			exp_item.character = chars[i];
			exp_item.last = (i == chars.size() - 1);
			expected_chars.push_back(exp_item);
		end
	endfunction

	task automatic queue_value(input logic [VALUE_WIDTH-1:0] value, input logic signed_flag,
			input logic [7:0] radix, input logic line_end);
		in_item_t item;
		item.value_bits = value;
		item.is_signed = signed_flag;
		item.radix = radix;
		item.add_line_end = line_end;
		pending_values.push_back(item);
	endtask

	function automatic logic [VALUE_WIDTH-1:0] random_value();
		logic [VALUE_WIDTH-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = $urandom_range(0, 999);
			6: v = -$urandom_range(1, 999);
			7: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = 1;
					2: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
					3: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
					default: v = '1;
				endcase
			end
			8: v = VALUE_WIDTH'(1) << $urandom_range(0, VALUE_WIDTH - 1);
			default: v = (VALUE_WIDTH'(1) << $urandom_range(0, VALUE_WIDTH - 1)) - 1;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] random_radix();
		logic [7:0] r;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7: r = DEFAULT_BASE;
			8: r = 8'($urandom_range(0, 1));
			9, 10, 11, 12, 13, 14: r = 8'($urandom_range(2, 36));
			15: r = 8'd2;
			16: r = 8'd16;
			default: r = 8'($urandom_range(37, 255));
		endcase
		return r;
	endfunction

	// Sender: bursts of transfers separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				predict_characters(in_data);
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_values.size() > 0) begin
				in_data <= pending_values.pop_front();
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
						: $urandom_range(1, 5);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each transfer and stalls in a pattern that is re-chosen at random as stall_timer advances.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected character %h with last %b", out_data.character,
						out_data.last);
					mismatch_count++;
				end else begin
					if (out_data.character !== expected_chars[0].character) begin
						$error("character: expected %h, got %h",
							expected_chars[0].character, out_data.character);
						mismatch_count++;
					end
					if (out_data.last !== expected_chars[0].last) begin
						$error("last: expected %b, got %b", expected_chars[0].last,
							out_data.last);
						mismatch_count++;
					end
					void'(expected_chars.pop_front());
				end
			end
			stall_timer++;
			if (stall_timer % 256 == 0) begin
				stall_mode = $urandom_range(0, 3);
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 9) < 6);
				2: out_ready <= (stall_timer % 8 == 7);
				default: out_ready <= stall_timer[0];
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		// Zero, the extremes of both signednesses and the most negative value.
		queue_value(32'h0000_0000, 1'b0, 8'd10, 1'b0);
		queue_value(32'h0000_0000, 1'b1, 8'd10, 1'b1);
		queue_value(32'hFFFF_FFFF, 1'b0, 8'd10, 1'b0);
		queue_value(32'hFFFF_FFFF, 1'b1, 8'd10, 1'b1);
		queue_value(32'h8000_0000, 1'b1, 8'd10, 1'b0);
		queue_value(32'h7FFF_FFFF, 1'b1, 8'd10, 1'b0);
		// A negative pattern outside base ten prints unsigned.
		queue_value(32'h8000_0000, 1'b1, 8'd16, 1'b0);
		queue_value(32'hFFFF_FFFF, 1'b1, 8'd16, 1'b1);
		// Longest output: 32 binary digits plus CR LF.
		queue_value(32'hFFFF_FFFF, 1'b1, 8'd2, 1'b1);
		// Bases below two fall back to ten.
		queue_value(32'd12345, 1'b0, 8'd0, 1'b0);
		queue_value(-32'sd5, 1'b1, 8'd1, 1'b1);
		// Large bases, including ones whose digits run beyond the letters, then assorted smaller bases.
		queue_value(32'hFFFF_FFFF, 1'b0, 8'd255, 1'b1);
		queue_value(32'h0000_00FE, 1'b0, 8'd255, 1'b0);
		queue_value(32'h0000_0000, 1'b0, 8'd255, 1'b1);
		queue_value(32'hDEAD_BEEF, 1'b0, 8'd36, 1'b0);
		queue_value(32'd1234567, 1'b0, 8'd37, 1'b0);
		queue_value(32'd35, 1'b0, 8'd36, 1'b0);
		queue_value(32'd36, 1'b0, 8'd37, 1'b1);
		queue_value(32'h0000_0001, 1'b1, 8'd3, 1'b0);
		queue_value(32'hA5A5_A5A5, 1'b0, 8'd8, 1'b1);
		queue_value(32'd9, 1'b0, 8'd10, 1'b0);
		queue_value(32'd10, 1'b0, 8'd10, 1'b1);
		queue_value(32'h5A5A_5A5A, 1'b1, 8'd128, 1'b0);
		for (int i = 0; i < RANDOM_VALUES; i++) begin
			queue_value(random_value(), 1'($urandom_range(0, 1)), random_radix(),
				1'($urandom_range(0, 1)));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_values.size() > 0 || in_valid) begin
			@(negedge clk);
		end
		while (expected_chars.size() > 0) begin
			@(negedge clk);
		end
		// Any stray character after the last expected one is caught by the receiver.
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/itoar_pkg.sv
rtl/itoar_seq.sv
rtl/itoar_datapath.sv
rtl/integer_to_ascii_radix_unit.sv
verif/tb_top.sv
